// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the breakpoint table interpolator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset held or not.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the asynchronous active-low reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/bti_pkg.sv =====
// Package for the breakpoint table interpolator: sizes, field widths and codes.
// No dependencies; imported by the top level.
`default_nettype none

package bti_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int MODE_W = 2;
	localparam int KEY_W = 16;
	localparam int VAL_W = 31;
	localparam int RES_W = 47;
	localparam int STAT_W = 2;
	localparam int FRAC_W = 16;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 48;

	// The divider retires two quotient bits per cycle over a 48-bit quotient.
	localparam int QUO_W = 48;
	localparam int DIV_STEPS = QUO_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/breakpoint_table_interpolator.sv =====
// Breakpoint table interpolator: the input slave channel takes clear, insert and query
// transfers, and the master channel returns one result transfer per input transfer.
// Uses the bti_pkg package and the assertion macros in assert_macros.svh.
// Usage:
//   s_tuser carries the mode (clear, insert, query); s_tdata carries key and value.
//   Every input transfer yields exactly one output transfer: m_tdata holds the
//   unsigned Q31.16 result and m_tuser the status (ok, table full, table empty).
//   Keys and values live in two synchronous memories of TABLE_DEPTH entries with
//   registered read ports; the entry count lives in a register.
//   Clear, empty-table queries and ignored items go straight to the output state.
//   An insert scans the stored entries once and then writes; an insert into an
//   empty table goes straight to the write.
//   A query scans the entries; an exact or out-of-range key then ends the item,
//   otherwise the multiply states MUL1 and MUL2, the SUM state and a radix-4
//   divider follow.
//   Only one item is at work at a time; s_tready is high while the sequencer idles.
//   The result sits in an output register, so the next item is accepted while the
//   previous result still waits for m_tready; a stalled receiver holds the result
//   and stops the next item only when its own result is ready to go out.
//   Reset empties the table; the memories themselves are not cleared.
`default_nettype none
`include "assert_macros.svh"

module breakpoint_table_interpolator import bti_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,  // entry_key, entry_value, zero pad
	input  wire logic [MODE_W-1:0]     s_tuser,  // mode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_DATA_W-1:0]        m_tdata,  // result_value, zero pad
	output logic [STAT_W-1:0]          m_tuser   // status
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_SUM = 3'd5;
	localparam logic [2:0] ST_DIV = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MODE_W-1:0]    mode_q;
	logic [KEY_W-1:0]     key_q;
	logic [VAL_W-1:0]     val_q;
	logic [RES_W-1:0]     res_q;
	logic [STAT_W-1:0]    status_q;

	logic [KEY_W-1:0]     key_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]     val_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]     key_rd_s1;
	logic [VAL_W-1:0]     val_rd_s1;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [CNT_W-1:0]     issue_q;

	logic                 found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic                 hit_q;
	logic [VAL_W-1:0]     hit_val_q;
	logic                 has_lo_q;
	logic [KEY_W-1:0]     lo_key_q;
	logic [VAL_W-1:0]     lo_val_q;
	logic                 has_hi_q;
	logic [KEY_W-1:0]     hi_key_q;
	logic [VAL_W-1:0]     hi_val_q;

	logic [RES_W-1:0]     prod1_q;
	logic [RES_W-1:0]     prod2_q;
	logic [KEY_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                 m_tvalid_q;
	logic [RES_W-1:0]     m_res_q;
	logic [STAT_W-1:0]    m_status_q;

	logic                 rd_en;
	logic                 scan_done;
	logic                 key_wr_en;
	logic                 val_wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [KEY_W-1:0]     span;
	logic [QUO_W-1:0]     num_sum;
	logic [KEY_W:0]       step_a;
	logic [KEY_W:0]       step_b;
	logic                 out_free;
	logic                 out_load;

	function automatic logic [KEY_W:0] div_step(input logic [KEY_W-1:0] rem,
			input logic dbit, input logic [KEY_W-1:0] dvs);
		logic [KEY_W:0] trial;
		logic [KEY_W:0] diff;
		trial = {rem, dbit};
		diff = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			div_step = {1'b1, diff[KEY_W-1:0]};
		end else begin
			div_step = {1'b0, trial[KEY_W-1:0]};
		end
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(M_DATA_W - RES_W){1'b0}}, m_res_q};
	assign m_tuser = m_status_q;

	assign rd_en = (state_q == ST_SCAN) && (issue_q < cnt_q);
	assign scan_done = (state_q == ST_SCAN) && (issue_q == cnt_q) && !rd_vld_s1;
	assign val_wr_en = (state_q == ST_WRITE) && (found_q || (cnt_q < CNT_W'(TABLE_DEPTH)));
	assign key_wr_en = (state_q == ST_WRITE) && !found_q && (cnt_q < CNT_W'(TABLE_DEPTH));
	assign wr_idx = found_q ? match_idx_q : cnt_q[IDX_W-1:0];

	assign span = hi_key_q - lo_key_q;
	assign num_sum = {1'b0, prod1_q} + {1'b0, prod2_q};
	assign step_a = div_step(rem_q, quo_q[QUO_W-1], span);
	assign step_b = div_step(step_a[KEY_W-1:0], quo_q[QUO_W-2], span);

	always_ff @(posedge clk) begin
		if (key_wr_en) begin
			key_mem[wr_idx] <= key_q;
		end
		if (rd_en) begin
			key_rd_s1 <= key_mem[issue_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (val_wr_en) begin
			val_mem[wr_idx] <= val_q;
		end
		if (rd_en) begin
			val_rd_s1 <= val_mem[issue_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= issue_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_res_q <= res_q;
			m_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			issue_q <= '0;
			div_cnt_q <= '0;
			found_q <= 1'b0;
			hit_q <= 1'b0;
			has_lo_q <= 1'b0;
			has_hi_q <= 1'b0;
			mode_q <= MODE_CLEAR;
			key_q <= '0;
			val_q <= '0;
			res_q <= '0;
			status_q <= STATUS_OK;
			match_idx_q <= '0;
			hit_val_q <= '0;
			lo_key_q <= '0;
			lo_val_q <= '0;
			hi_key_q <= '0;
			hi_val_q <= '0;
			prod1_q <= '0;
			prod2_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					found_q <= 1'b0;
					hit_q <= 1'b0;
					has_lo_q <= 1'b0;
					has_hi_q <= 1'b0;
					if (s_tvalid) begin
						mode_q <= s_tuser;
						key_q <= s_tdata[KEY_W-1:0];
						val_q <= s_tdata[KEY_W+VAL_W-1:KEY_W];
						res_q <= '0;
						status_q <= ((s_tuser == MODE_QUERY) && (cnt_q == '0)) ?
							STATUS_EMPTY : STATUS_OK;
						case (s_tuser)
							MODE_CLEAR: begin
								cnt_q <= '0;
								state_q <= ST_OUT;
							end
							MODE_INSERT: begin
								if (s_tdata[KEY_W-1:0] == '0) begin
									state_q <= ST_OUT;
								end else if (cnt_q == '0) begin
									state_q <= ST_WRITE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							MODE_QUERY: begin
								if (cnt_q == '0) begin
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (mode_q == MODE_INSERT) begin
							if (key_rd_s1 == key_q) begin
								found_q <= 1'b1;
								match_idx_q <= idx_s1;
							end
						end else begin
							if (key_rd_s1 == key_q) begin
								hit_q <= 1'b1;
								hit_val_q <= val_rd_s1;
							end
							if ((key_rd_s1 < key_q) && (!has_lo_q || key_rd_s1 > lo_key_q)) begin
								has_lo_q <= 1'b1;
								lo_key_q <= key_rd_s1;
								lo_val_q <= val_rd_s1;
							end
							if ((key_rd_s1 > key_q) && (!has_hi_q || key_rd_s1 < hi_key_q)) begin
								has_hi_q <= 1'b1;
								hi_key_q <= key_rd_s1;
								hi_val_q <= val_rd_s1;
							end
						end
					end
					if (scan_done) begin
						if (mode_q == MODE_INSERT) begin
							state_q <= ST_WRITE;
						end else if (hit_q) begin
							res_q <= {hit_val_q, {FRAC_W{1'b0}}};
							state_q <= ST_OUT;
						end else if (!has_lo_q) begin
							res_q <= {hi_val_q, {FRAC_W{1'b0}}};
							state_q <= ST_OUT;
						end else if (!has_hi_q) begin
							res_q <= {lo_val_q, {FRAC_W{1'b0}}};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_WRITE: begin
					if (!found_q) begin
						if (cnt_q < CNT_W'(TABLE_DEPTH)) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							status_q <= STATUS_FULL;
						end
					end
					state_q <= ST_OUT;
				end
				ST_MUL1: begin
					prod1_q <= RES_W'(lo_val_q) * RES_W'(hi_key_q - key_q);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					prod2_q <= RES_W'(hi_val_q) * RES_W'(key_q - lo_key_q);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					rem_q <= num_sum[QUO_W-1:QUO_W-KEY_W];
					quo_q <= {num_sum[QUO_W-KEY_W-1:0], {FRAC_W{1'b0}}};
					div_cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= step_b[KEY_W-1:0];
					quo_q <= {quo_q[QUO_W-3:0], step_a[KEY_W], step_b[KEY_W]};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						res_q <= {quo_q[RES_W-3:0], step_a[KEY_W], step_b[KEY_W]};
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_RST(a_count_bound, clk, arst_n, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count overflow")
	`ASSERT_RST(a_busy_after_accept, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
	`ASSERT_RST(a_empty_is_zero, clk, arst_n, (m_tvalid && m_tuser == STATUS_EMPTY) |-> (m_tdata == '0), "empty query result not zero")
	`ASSERT_RST(a_out_stable, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

`default_nettype wire
